// ===== hw/rtl/indexed_list_insert_remove_macros.svh =====
// Assertion macros used by the assertion checker file.
`ifndef INDEXED_LIST_INSERT_REMOVE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ILIR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ILIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ilir_pkg.sv =====
`default_nettype none
package ilir_pkg;

    // Field widths of the request and result words
    localparam int CMD_W = 3;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;
    localparam int IN_W  = 40;
    localparam int OUT_W = 40;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_FILL   = 3'd4
    } t_cmd;

    // Status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOR  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Decoded command kind, at most one bit set
    typedef struct packed {
        logic rd;
        logic wr;
        logic ins;
        logic rem;
        logic fill;
    } t_ctl;

    // Classified request passed from front to back
    typedef struct packed {
        t_ctl                     ctl;
        logic [POS_W-1:0]         pos;
        logic signed [VAL_W-1:0]  value;
    } t_req;

endpackage
`default_nettype wire

// ===== hw/rtl/ilir_front.sv =====
`default_nettype none
module ilir_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [2:0] cmd, [7:3] position, [39:8] value
    input  wire logic [ilir_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                             o_req_valid,
    input  wire logic                        i_req_ready,
    output ilir_pkg::t_req                   o_req
);

    logic             r_valid;
    ilir_pkg::t_req   r_req;
    ilir_pkg::t_req   n_req;
    ilir_pkg::t_cmd   w_cmd;

    assign w_cmd = ilir_pkg::t_cmd'(i_s_axis_tdata[2:0]);

    // Decode the command into one-hot kind flags; unused codes get none
    always_comb begin
        n_req       = '0;
        n_req.pos   = i_s_axis_tdata[7:3];
        n_req.value = i_s_axis_tdata[39:8];
        unique case (w_cmd)
            ilir_pkg::CMD_READ:   n_req.ctl.rd   = 1'b1;
            ilir_pkg::CMD_WRITE:  n_req.ctl.wr   = 1'b1;
            ilir_pkg::CMD_INSERT: n_req.ctl.ins  = 1'b1;
            ilir_pkg::CMD_REMOVE: n_req.ctl.rem  = 1'b1;
            ilir_pkg::CMD_FILL:   n_req.ctl.fill = 1'b1;
            default:              n_req.ctl      = '0;
        endcase
    end

    assign o_s_axis_tready = !r_valid || i_req_ready;
    assign o_req_valid     = r_valid;
    assign o_req           = r_req;

    // Input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_req <= n_req;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ilir_queue.sv =====
`default_nettype none
module ilir_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire ilir_pkg::t_req i_push_req,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output ilir_pkg::t_req     o_pop_req
);

    // Two-entry FIFO between front and back
    ilir_pkg::t_req r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_req    = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= !r_wptr;
            if (w_pop)  r_rptr <= !r_rptr;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_req;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ilir_back.sv =====
`default_nettype none
module ilir_back #(
    parameter int CAPACITY = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    output logic                             o_req_ready,
    input  wire ilir_pkg::t_req              i_req,
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // [31:0] read_value, [33:32] status, [38:34] length, [39] zero
    output logic [ilir_pkg::OUT_W-1:0]       o_m_axis_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W;
    localparam int IW = $clog2(CAPACITY);
    localparam int LW = ilir_pkg::LEN_W;
    localparam int VW = ilir_pkg::VAL_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic signed [VW-1:0]        r_cell [CAPACITY];
    logic signed [VW-1:0]        n_cell [CAPACITY];
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_out_valid;
    logic [ilir_pkg::OUT_W-1:0]  r_out_data;

    logic                        w_fire;
    logic [PW-1:0]               w_pos;
    logic [PW-1:0]               w_cnt;
    logic                        w_in_rng;
    logic                        w_full;
    logic                        w_wr_ok;
    logic                        w_ins_ok;
    logic                        w_rem_ok;
    logic signed [VW-1:0]        w_rd_data;
    logic signed [VW-1:0]        w_rd_value;
    ilir_pkg::t_status           w_status;

    assign o_req_ready = !r_out_valid || i_m_axis_tready;
    assign w_fire      = i_req_valid && o_req_ready;

    // Range checks against the current length
    assign w_pos    = PW'(i_req.pos);
    assign w_cnt    = PW'(r_count);
    assign w_in_rng = (w_pos < w_cnt);
    assign w_full   = (r_count >= CAP_C);
    assign w_wr_ok  = i_req.ctl.wr && w_in_rng;
    assign w_ins_ok = i_req.ctl.ins && !w_full && (w_pos <= w_cnt);
    assign w_rem_ok = i_req.ctl.rem && w_in_rng;

    // Entry read; only used when the position is in range
    assign w_rd_data = r_cell[w_pos[IW-1:0]];

    // Result value, status and new length
    always_comb begin
        w_rd_value = '0;
        w_status   = ilir_pkg::ST_OK;
        n_count    = r_count;
        if (i_req.ctl.rd) begin
            if (w_in_rng) begin
                w_rd_value = w_rd_data;
            end else begin
                w_rd_value = '1;
                w_status   = ilir_pkg::ST_OOR;
            end
        end
        if (i_req.ctl.wr && !w_in_rng)  w_status = ilir_pkg::ST_OOR;
        if (i_req.ctl.rem && !w_in_rng) w_status = ilir_pkg::ST_OOR;
        if (i_req.ctl.ins) begin
            if (w_full) begin
                w_status = ilir_pkg::ST_FULL;
            end else if (w_pos > w_cnt) begin
                w_status = ilir_pkg::ST_OOR;
            end
        end
        if (w_ins_ok)       n_count = r_count + CW'(1);
        if (w_rem_ok)       n_count = r_count - CW'(1);
        if (i_req.ctl.fill) n_count = CAP_C;
    end

    // Per-entry cells: each keeps its own value or takes the request value, its lower or upper neighbor
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [PW-1:0] IDX = PW'(gi);
        logic signed [VW-1:0] w_lower;
        logic signed [VW-1:0] w_upper;

        if (gi > 0) begin : g_lo
            assign w_lower = r_cell[gi-1];
        end else begin : g_lo0
            assign w_lower = r_cell[gi];
        end

        if (gi < CAPACITY - 1) begin : g_up
            assign w_upper = r_cell[gi+1];
        end else begin : g_up_last
            assign w_upper = r_cell[gi];
        end

        always_comb begin
            n_cell[gi] = r_cell[gi];
            if (i_req.ctl.fill) begin
                n_cell[gi] = i_req.value;
            end else if (w_wr_ok && (IDX == w_pos)) begin
                n_cell[gi] = i_req.value;
            end else if (w_ins_ok) begin
                if (IDX == w_pos) begin
                    n_cell[gi] = i_req.value;
                end else if (IDX > w_pos) begin
                    n_cell[gi] = w_lower;
                end
            end else if (w_rem_ok && (IDX >= w_pos)) begin
                n_cell[gi] = w_upper;
            end
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_cell <= n_cell;
        end
    end

    // Length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_fire) begin
            r_count <= n_count;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_req_ready) begin
            r_out_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {1'b0, LW'(n_count), w_status, w_rd_value};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_list_insert_remove.sv =====
// Indexed list with insert and remove.
// Requests arrive on the s_axis channel, one command each: tdata holds
// cmd [2:0], position [7:3] and value [39:8]. Every request gives exactly
// one result on the m_axis channel: read_value [31:0], status [33:32] and
// the length after the command [38:34].
// Path: an input register classifies the command, a two-entry queue
// decouples it from the back end, and the back end updates one register
// cell per entry (cells from the position upward shift together on insert
// and remove) and loads the output register.
// Each result passes in order through the input register, the queue and
// the output register before it reaches m_axis.
// Throughput: one request per cycle while m_axis tready stays high.
// Reset (synchronous, active low) empties the list and the queue and drops
// any pending result; entry contents are left as they were.
// When the receiver stalls, the result holds in the output register, the
// queue and the input register fill, and then s_axis tready falls.
`default_nettype none
module indexed_list_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [2:0] cmd, [7:3] position, [39:8] value
    input  wire logic [ilir_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // [31:0] read_value, [33:32] status, [38:34] length, [39] zero
    output logic [ilir_pkg::OUT_W-1:0]      o_m_axis_tdata
);

    logic            w_f_valid;
    logic            w_f_ready;
    ilir_pkg::t_req  w_f_req;
    logic            w_b_valid;
    logic            w_b_ready;
    ilir_pkg::t_req  w_b_req;

    // Front: accept and classify
    ilir_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_req_valid     (w_f_valid),
        .i_req_ready     (w_f_ready),
        .o_req           (w_f_req)
    );

    // Decoupling queue
    ilir_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_req   (w_f_req),
        .o_pop_valid  (w_b_valid),
        .i_pop_ready  (w_b_ready),
        .o_pop_req    (w_b_req)
    );

    // Back: list cells and result register
    ilir_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (w_b_valid),
        .o_req_ready     (w_b_ready),
        .i_req           (w_b_req),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/ilir_checker.sv =====
`default_nettype none
`include "indexed_list_insert_remove_macros.svh"
module ilir_checker #(
    parameter int CAPACITY = 16
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_s_axis_tvalid,
    input wire logic                       o_s_axis_tready,
    input wire logic [ilir_pkg::IN_W-1:0]  i_s_axis_tdata,
    input wire logic                       o_m_axis_tvalid,
    input wire logic                       i_m_axis_tready,
    input wire logic [ilir_pkg::OUT_W-1:0] o_m_axis_tdata
);

    localparam logic [4:0] CAP_LEN = 5'(CAPACITY);

    logic       w_out_stall;
    logic [1:0] w_status;
    logic [4:0] w_length;
    logic       w_in_idle;

    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_status    = o_m_axis_tdata[33:32];
    assign w_length    = o_m_axis_tdata[38:34];
    assign w_in_idle   = !i_s_axis_tvalid && (i_s_axis_tdata == i_s_axis_tdata);

    // A stalled result holds
    `ILIR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")

    // Status is one of the defined codes
    `ILIR_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_m_axis_tvalid, w_status != 2'd3, "undefined status code")

    // A refused insert reports a full list
    `ILIR_ASSERT_NOW(a_full_len, i_clk, i_rst_n, o_m_axis_tvalid && (w_status == ilir_pkg::ST_FULL), w_length == CAP_LEN, "full status with short length")

    // Length never exceeds the capacity
    `ILIR_ASSERT_NOW(a_len_max, i_clk, i_rst_n, o_m_axis_tvalid && (CAPACITY < 32), w_length <= CAP_LEN, "length above capacity")

    // Nothing comes out the cycle after reset with no request in flight
    `ILIR_ASSERT_NEXT(a_rst_empty, i_clk, 1'b1, !i_rst_n && w_in_idle, !o_m_axis_tvalid, "result right after reset")

endmodule

bind indexed_list_insert_remove ilir_checker #(
    .CAPACITY (CAPACITY)
) u_ilir_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

// ===== tb/list_result_checker.sv =====
// Watches both stream channels of the indexed list, keeps its own copy of the
// list, predicts the result of every accepted request and compares each
// returned result with the oldest prediction.
module list_result_checker
    import ilir_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    input  wire logic              i_s_axis_tready,
    // [2:0] cmd, [7:3] position, [39:8] value
    input  wire logic [IN_W-1:0]   i_s_axis_tdata,
    input  wire logic              i_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // [31:0] read_value, [33:32] status, [38:34] length, [39] zero
    input  wire logic [OUT_W-1:0]  i_m_axis_tdata,
    output int                     o_fail_cnt,
    output int                     o_pending,
    output int                     o_list_len
);

    typedef struct packed {
        logic [VAL_W-1:0] rd_val;
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] len;
    } t_list_result;

    // Shadow copy of the list
    logic [VAL_W-1:0] list_store [CAPACITY];
    int               list_len = 0;

    t_list_result expected_results [$];
    int           fail_cnt = 0;

    // Apply one command to the shadow list and return the result it gives
    function automatic t_list_result predict_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [VAL_W-1:0] val);
        t_list_result res;
        int           p;
        p          = int'(pos);
        res.rd_val = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_READ: begin
                if (p < list_len) begin
                    res.rd_val = list_store[p];
                end else begin
                    res.rd_val = '1;
                    res.status = ST_OOR;
                end
            end
            CMD_WRITE: begin
                if (p < list_len) list_store[p] = val;
                else res.status = ST_OOR;
            end
            CMD_INSERT: begin
                // a full list is refused before the position is looked at
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (p > list_len) begin
                    res.status = ST_OOR;
                end else begin
                    for (int i = list_len; i > p; i--) list_store[i] = list_store[i-1];
                    list_store[p] = val;
                    list_len++;
                end
            end
            CMD_REMOVE: begin
                if (p < list_len) begin
                    for (int i = p; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
                    list_len--;
                end else begin
                    res.status = ST_OOR;
                end
            end
            CMD_FILL: begin
                for (int i = 0; i < CAPACITY; i++) list_store[i] = val;
                list_len = CAPACITY;
            end
            default: ;  // unused codes leave everything alone
        endcase
        res.len = LEN_W'(list_len);
        return res;
    endfunction

    // Compare returned results, then predict newly accepted requests
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.rd_val = i_m_axis_tdata[31:0];
                got.status = i_m_axis_tdata[33:32];
                got.len    = i_m_axis_tdata[38:34];
                if (expected_results.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("%0t: result with no request pending: rd=%0d st=%0d len=%0d",
                                 $realtime, $signed(got.rd_val), got.status, got.len);
                    fail_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        if (fail_cnt < 10)
                            $display({"%0t: mismatch: expected rd=%0d st=%0d len=%0d,",
                                      " got rd=%0d st=%0d len=%0d"},
                                     $realtime, $signed(want.rd_val), want.status,
                                     want.len, $signed(got.rd_val), got.status, got.len);
                        fail_cnt++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_results.push_back(predict_command(i_s_axis_tdata[2:0],
                                                           i_s_axis_tdata[7:3],
                                                           i_s_axis_tdata[39:8]));
        end
        o_fail_cnt <= fail_cnt;
        o_pending  <= expected_results.size();
        o_list_len <= list_len;
    end

endmodule

// ===== tb/testbench.sv =====
// Drives commands into the indexed list under varying back pressure and
// gives the verdict from the checker's failure and pending counts and a watchdog.
module testbench;
    import ilir_pkg::*;

    localparam int LIST_CAP    = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 575;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic [IN_W-1:0]  s_data = '0;
    logic             m_ready = 1'b0;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [OUT_W-1:0] o_m_axis_tdata;

    int fail_cnt;
    int pend_cnt;
    int list_len;

    int send_idle_pct = 29;
    int recv_idle_pct = 62;
    int stall_asked = 0;
    int stall_done = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    indexed_list_insert_remove #(.CAPACITY(LIST_CAP)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    list_result_checker #(.CAPACITY(LIST_CAP)) result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_fail_cnt      (fail_cnt),
        .o_pending       (pend_cnt),
        .o_list_len      (list_len)
    );

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_asked != stall_done) begin
            m_ready    <= 1'b0;
            stall_done <= stall_asked;
            hold_left  <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one request, with random gaps ahead of it; return once accepted
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {val, pos, cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Stop sending until every pending result is back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pend_cnt != 0) @(posedge i_clk);
    endtask

    // Random walk of the list length between empty and full
    task automatic run_random(input int n_items, input bit long_hold);
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int               pick;
        int               len;
        bit               grow;
        grow = 1'b1;
        for (int n = 0; n < n_items; n++) begin
            if (long_hold && n == n_items / 3) stall_asked <= stall_asked + 1;
            if (n == n_items / 2) drain();
            len = list_len;
            if (len >= LIST_CAP) grow = 1'b0;
            else if (len == 0) grow = 1'b1;
            else if ($urandom_range(49) == 0) grow = !grow;

            pick = $urandom_range(99);
            if (pick < 2) cmd = CMD_FILL;
            else if (pick < 4) cmd = CMD_W'($urandom_range(2**CMD_W - 1, int'(CMD_FILL) + 1));
            else if (pick < 30) cmd = grow ? CMD_INSERT : CMD_REMOVE;
            else if (pick < 40) cmd = grow ? CMD_REMOVE : CMD_INSERT;
            else if (pick < 72) cmd = CMD_READ;
            else cmd = CMD_WRITE;

            // mostly in range, sometimes anything the field holds
            if ($urandom_range(99) < 12) pos = POS_W'($urandom);
            else if (cmd == CMD_INSERT) pos = POS_W'($urandom_range(len));
            else if (len == 0) pos = '0;
            else pos = POS_W'($urandom_range(len - 1));

            case ($urandom_range(7))
                0: val = 32'h7FFF_FFFF;
                1: val = 32'h8000_0000;
                2: val = '1;
                3: val = '0;
                default: val = $urandom;
            endcase
            send_cmd(cmd, pos, val);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, appends, extremes, full list, unused codes
        send_cmd(CMD_READ,   5'd0,  32'h1);
        send_cmd(CMD_WRITE,  5'd0,  32'h2);
        send_cmd(CMD_REMOVE, 5'd0,  32'h3);
        send_cmd(CMD_INSERT, 5'd1,  32'h4);
        send_cmd(CMD_INSERT, 5'd0,  32'h7FFF_FFFF);
        send_cmd(CMD_INSERT, 5'd1,  32'h8000_0000);
        send_cmd(CMD_INSERT, 5'd0,  32'hFFFF_FFFF);
        send_cmd(CMD_READ,   5'd0,  32'h0);
        send_cmd(CMD_READ,   5'd1,  32'h0);
        send_cmd(CMD_READ,   5'd2,  32'h0);
        send_cmd(CMD_READ,   5'd3,  32'h0);
        send_cmd(CMD_WRITE,  5'd1,  32'h0);
        send_cmd(CMD_WRITE,  5'd3,  32'h5);
        send_cmd(CMD_REMOVE, 5'd0,  32'h0);
        send_cmd(CMD_REMOVE, 5'd1,  32'h0);
        send_cmd(CMD_FILL,   5'd31, 32'h8000_0000);
        send_cmd(CMD_INSERT, 5'd31, 32'h6);
        send_cmd(CMD_INSERT, 5'd0,  32'h7);
        send_cmd(CMD_READ,   5'd15, 32'h0);
        send_cmd(CMD_READ,   5'd16, 32'h0);
        send_cmd(CMD_READ,   5'd31, 32'h0);
        send_cmd(CMD_WRITE,  5'd15, 32'h1234_5678);
        send_cmd(CMD_REMOVE, 5'd15, 32'h0);
        for (int c = int'(CMD_FILL) + 1; c < 2**CMD_W; c++)
            send_cmd(CMD_W'(c), 5'd31, 32'hFFFF_FFFF);

        run_random(PHASE_ITEMS, 1'b0);
        drain();
        send_idle_pct <= 62;
        recv_idle_pct <= 29;
        run_random(PHASE_ITEMS, 1'b0);
        drain();
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        run_random(PHASE_ITEMS, 1'b1);
        drain();

        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && pend_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ilir_pkg.sv
hw/rtl/ilir_front.sv
hw/rtl/ilir_queue.sv
hw/rtl/ilir_back.sv
hw/rtl/indexed_list_insert_remove.sv
hw/rtl/ilir_checker.sv
tb/list_result_checker.sv
tb/testbench.sv
